// ----- rtl/core/twrr_pkg.sv -----
// Package for the two-level weighted round-robin scheduler.
// Holds the field widths, register indexes, count update codes and the group
// search result type. Depends on nothing.
`default_nettype none

package twrr_pkg;

	localparam int MASK_W     = 8;   // one bit per slot, widest configuration
	localparam int SLOT_W     = 3;   // slot index width
	localparam int CFG_DATA_W = 64;  // widest configuration register
	localparam int CFG_IDX_W  = 1;   // two registers

	localparam logic [CFG_IDX_W-1:0] REG_PART_WEIGHTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MASK    = 1'b1;

	// How a group's grant count moves after a request.
	localparam logic [1:0] CNT_KEEP = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_ONE  = 2'd2;
	localparam logic [1:0] CNT_ZERO = 2'd3;

	typedef struct packed {
		logic              grant;
		logic [SLOT_W-1:0] ptr;
		logic [1:0]        cnt_op;
	} grp_res_t;

	// Lowest set bit of a member vector, zero when the vector is empty.
	function automatic logic [SLOT_W-1:0] first_slot(input logic [MASK_W-1:0] member);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (member[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/two_level_weighted_round_robin.sv -----
// Two-level weighted round-robin scheduler: a request word passes through the
// request register, the combinational group search and the grant register;
// one request word is accepted every cycle unless m_axis_tready holds up a
// full grant register. The pointer and count update as a word enters the
// grant register. arst_n clears both configuration registers, both pointers
// and both counts and empties the request and grant registers. Depends on twrr_pkg.
`default_nettype none

module two_level_weighted_round_robin
	import twrr_pkg::*;
#(
	parameter int NUM_SLOTS = 8,  // 1 to 8
	parameter int PART_BITS = 8   // 1 to 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Request side.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,   // [7:0] nonempty_mask
	// Grant side.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,   // [0] granted, [3:1] chosen_slot,
	                                                   // [4] from_high, [7:5] zero
	// Configuration writes.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] part_q;
	logic [MASK_W-1:0]     high_mask_q;
	logic [CFG_DATA_W-1:0] part_next;
	logic [MASK_W-1:0]     high_mask_next;

	// Scheduler state, one pointer and one grant count per group.
	logic [SLOT_W-1:0]    hi_ptr_q, lo_ptr_q;
	logic [PART_BITS-1:0] hi_cnt_q, lo_cnt_q;

	// Request register and grant register.
	logic              valid_s1;
	logic [MASK_W-1:0] mask_s1;
	logic              valid_s2;
	logic [7:0]        data_s2;

	logic adv_s2, fire_s1;

	// Group membership from the live and the about-to-be-written configuration.
	logic [MASK_W-1:0] hi_member, lo_member, hi_member_next, lo_member_next;

	logic [SLOT_W-1:0] hi_p0, lo_p0;
	logic              hi_below, lo_below;
	grp_res_t          hi_res, lo_res;

	logic              res_granted, res_high;
	logic [SLOT_W-1:0] res_slot;

	// Part of one slot, taken from a packed register value.
	function automatic logic [PART_BITS-1:0] part_of(input logic [CFG_DATA_W-1:0] parts,
			input logic [SLOT_W-1:0] slot);
		return parts[slot * PART_BITS +: PART_BITS];
	endfunction

	// Used slots of one group: in range, a non-zero part and the right group bit.
	function automatic logic [MASK_W-1:0] members(input logic [CFG_DATA_W-1:0] parts,
			input logic [MASK_W-1:0] hmask, input logic want_high);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < NUM_SLOTS) begin
				m[i] = (parts[i * PART_BITS +: PART_BITS] != '0) && (hmask[i] == want_high);
			end
		end
		return m;
	endfunction

	// Where the search starts: the stored pointer when it still names a used
	// slot, otherwise the group's lowest used slot.
	function automatic logic [SLOT_W-1:0] start_slot(input logic [MASK_W-1:0] member,
			input logic [SLOT_W-1:0] ptr);
		return member[ptr] ? ptr : first_slot(member);
	endfunction

	// One group's decision. The start slot keeps the grant while its queue is
	// non-empty and its count is below its part; otherwise the next used slot
	// with a non-empty queue in cyclic order wins, the start slot itself last.
	function automatic grp_res_t pick_group(input logic [MASK_W-1:0] member,
			input logic [MASK_W-1:0] avail, input logic [SLOT_W-1:0] ptr,
			input logic [SLOT_W-1:0] p0, input logic below);
		grp_res_t r;
		int       j;
		logic     found;
		r.grant  = 1'b0;
		r.ptr    = p0;
		r.cnt_op = CNT_ZERO;
		found    = 1'b0;
		if (member == '0) begin
			r.ptr    = ptr;
			r.cnt_op = CNT_KEEP;
		end else if (avail[p0] && below) begin
			r.grant  = 1'b1;
			r.cnt_op = CNT_INC;
		end else begin
			for (int k = 1; k <= NUM_SLOTS; k++) begin
				j = int'(p0) + k;
				if (j >= NUM_SLOTS) begin
					j = j - NUM_SLOTS;
				end
				if (!found && member[j] && avail[j]) begin
					found = 1'b1;
					r.ptr = SLOT_W'(j);
				end
			end
			if (found) begin
				r.grant  = 1'b1;
				r.cnt_op = CNT_ONE;
			end
		end
		return r;
	endfunction

	// Count update for one group.
	function automatic logic [PART_BITS-1:0] next_cnt(input logic [PART_BITS-1:0] cnt,
			input logic [1:0] op);
		logic [PART_BITS-1:0] n;
		case (op)
			CNT_INC:  n = cnt + PART_BITS'(1);
			CNT_ONE:  n = PART_BITS'(1);
			CNT_ZERO: n = '0;
			default:  n = cnt;
		endcase
		return n;
	endfunction

	// Handshake. The grant register frees itself when taken, so a request is
	// accepted in the same cycle in which the previous grant leaves.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign fire_s1       = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	// Configuration values after this cycle's write, used to place the
	// pointers on the first used slot of each group.
	always_comb begin
		part_next      = part_q;
		high_mask_next = high_mask_q;
		if (cfg_we) begin
			case (cfg_index)
				REG_PART_WEIGHTS: part_next      = cfg_data;
				REG_HIGH_MASK:    high_mask_next = cfg_data[MASK_W-1:0];
				default:          ;
			endcase
		end
	end

	// The group search. The high group is always searched and its state always
	// moves; the low group only counts when the high group granted nothing.
	always_comb begin
		hi_member      = members(part_q, high_mask_q, 1'b1);
		lo_member      = members(part_q, high_mask_q, 1'b0);
		hi_member_next = members(part_next, high_mask_next, 1'b1);
		lo_member_next = members(part_next, high_mask_next, 1'b0);

		hi_p0    = start_slot(hi_member, hi_ptr_q);
		lo_p0    = start_slot(lo_member, lo_ptr_q);
		hi_below = hi_cnt_q < part_of(part_q, hi_p0);
		lo_below = lo_cnt_q < part_of(part_q, lo_p0);

		hi_res = pick_group(hi_member, mask_s1, hi_ptr_q, hi_p0, hi_below);
		lo_res = pick_group(lo_member, mask_s1, lo_ptr_q, lo_p0, lo_below);

		if (hi_res.grant) begin
			res_granted = 1'b1;
			res_slot    = hi_res.ptr;
			res_high    = 1'b1;
		end else if (lo_res.grant) begin
			res_granted = 1'b1;
			res_slot    = lo_res.ptr;
			res_high    = 1'b0;
		end else begin
			res_granted = 1'b0;
			res_slot    = '0;
			res_high    = 1'b0;
		end
	end

	// Configuration and scheduler state. A configuration write puts each
	// pointer on its group's lowest used slot and clears both counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q      <= '0;
			high_mask_q <= '0;
			hi_ptr_q    <= '0;
			lo_ptr_q    <= '0;
			hi_cnt_q    <= '0;
			lo_cnt_q    <= '0;
		end else if (cfg_we) begin
			part_q      <= part_next;
			high_mask_q <= high_mask_next;
			hi_ptr_q    <= first_slot(hi_member_next);
			lo_ptr_q    <= first_slot(lo_member_next);
			hi_cnt_q    <= '0;
			lo_cnt_q    <= '0;
		end else if (fire_s1) begin
			hi_ptr_q <= hi_res.ptr;
			hi_cnt_q <= next_cnt(hi_cnt_q, hi_res.cnt_op);
			if (!hi_res.grant) begin
				lo_ptr_q <= lo_res.ptr;
				lo_cnt_q <= next_cnt(lo_cnt_q, lo_res.cnt_op);
			end
		end
	end

	// Valid flags of the request and grant registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payloads: the request word and the packed grant word.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mask_s1 <= s_axis_tdata;
		end
		if (fire_s1) begin
			data_s2 <= {3'b000, res_high, res_slot, res_granted};
		end
	end

`ifndef NO_ASSERTIONS
	// A grant always names a slot whose queue was reported non-empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_granted |-> mask_s1[res_slot])
		else $error("grant to an empty queue");

	// A group's count never exceeds the part of the slot its pointer names.
	assert property (@(posedge clk) disable iff (!arst_n)
		hi_member[hi_ptr_q] |-> hi_cnt_q <= part_of(part_q, hi_ptr_q))
		else $error("high group count beyond its part");

	assert property (@(posedge clk) disable iff (!arst_n)
		lo_member[lo_ptr_q] |-> lo_cnt_q <= part_of(part_q, lo_ptr_q))
		else $error("low group count beyond its part");

	// With the grant register empty the request side is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("request stalled with grant register empty");
`endif

endmodule

`default_nettype wire

// ----- dv/two_level_weighted_round_robin_tb.sv -----
// Self-checking testbench for the two-level weighted round-robin scheduler.
// Drives request words with random gaps, predicts each grant word, checks it.
// Depends on twrr_pkg and the two_level_weighted_round_robin RTL only.

module two_level_weighted_round_robin_tb;
	import twrr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The grant word's fields, last field in the lowest bit.
	typedef struct packed {
		logic       from_high;
		logic [2:0] chosen_slot;
		logic       granted;
	} grant_t;

	// Shapes of request mask that a run of words may take.
	typedef enum int {
		REQ_FRESH,    // a new random mask for every word
		REQ_HOLD,     // the same random mask held for the whole run
		REQ_ONE_HOT,  // a single non-empty queue per word
		REQ_ALL,      // every queue non-empty
		REQ_NONE      // every queue empty
	} req_kind_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Request masks waiting to be presented, and grants still owed by the block.
	logic [7:0] pending_masks[$];
	grant_t     expected_grants[$];

	int mismatches = 0;
	int src_gap    = 0;
	int sink_gap   = 0;
	bit no_idle    = 1'b0;
	bit req_taken  = 1'b0;

	// Predictor state: our own copy of both registers, both pointers and both
	// grant counts.
	logic [63:0] mdl_parts = '0;
	logic [7:0]  mdl_high  = '0;
	logic [2:0]  hi_ptr    = '0;
	logic [7:0]  hi_cnt    = '0;
	logic [2:0]  lo_ptr    = '0;
	logic [7:0]  lo_cnt    = '0;

	two_level_weighted_round_robin i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [7:0] part_of(input int slot);
		return mdl_parts[8*slot +: 8];
	endfunction

	// A slot takes part in a group only when its part is non-zero.
	function automatic bit belongs(input int slot, input bit hi);
		return part_of(slot) != 8'd0 && mdl_high[slot] == hi;
	endfunction

	function automatic logic [2:0] lowest_in(input bit hi);
		int i;
		for (i = 0; i < 8; i++) begin
			if (belongs(i, hi)) begin
				return 3'(i);
			end
		end
		return 3'd0;
	endfunction

	function automatic logic [2:0] following_in(input logic [2:0] p, input bit hi);
		int k;
		int j;
		for (k = 1; k <= 8; k++) begin
			j = (int'(p) + k) % 8;
			if (belongs(j, hi)) begin
				return 3'(j);
			end
		end
		return p;
	endfunction

	// Searches one group. The pointer stays on its slot while that queue is
	// non-empty and under its part; otherwise it walks the group in slot order,
	// clearing the count, with the start slot tried last. For a non-empty group
	// the pointer and count are written back even when nothing is granted.
	function automatic bit search_group(input bit hi, input logic [7:0] req,
			inout logic [2:0] ptr, inout logic [7:0] cnt);
		logic [2:0] p;
		logic [2:0] start;
		int         c;
		int         k;
		if (!belongs(int'(lowest_in(hi)), hi)) begin
			return 1'b0;
		end
		p = ptr;
		if (!belongs(int'(p), hi)) begin
			p = lowest_in(hi);
		end
		c = int'(cnt);
		start = p;
		for (k = 0; k < 8; k++) begin
			if (req[p] && c < int'(part_of(int'(p)))) begin
				break;
			end
			p = following_in(p, hi);
			c = 0;
			if (p == start) begin
				break;
			end
		end
		ptr = p;
		if (!req[p]) begin
			cnt = c[7:0];
			return 1'b0;
		end
		cnt = 8'(c + 1);
		return 1'b1;
	endfunction

	// The high group always gets the first look; the low group only when the
	// high group grants nothing.
	function automatic grant_t predict_grant(input logic [7:0] req);
		grant_t g;
		g = '0;
		if (search_group(1'b1, req, hi_ptr, hi_cnt)) begin
			g.granted     = 1'b1;
			g.chosen_slot = hi_ptr;
			g.from_high   = 1'b1;
		end else if (search_group(1'b0, req, lo_ptr, lo_cnt)) begin
			g.granted     = 1'b1;
			g.chosen_slot = lo_ptr;
		end
		return g;
	endfunction

	// Any register write sends both pointers home and clears both counts.
	function automatic void regroup();
		hi_ptr = lowest_in(1'b1);
		lo_ptr = lowest_in(1'b0);
		hi_cnt = '0;
		lo_cnt = '0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t ns] %s", $time, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Request driver: presents words from pending_masks at the falling edge,
	// with an occasional burst of idle cycles after an accepted word.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic       nv;
		logic [7:0] nd;
		nv = s_axis_tvalid;
		nd = s_axis_tdata;
		if (arst_n && (req_taken || !s_axis_tvalid)) begin
			nv = 1'b0;
			if (src_gap > 0 && !no_idle) begin
				src_gap--;
			end else if (pending_masks.size() != 0) begin
				nd = pending_masks.pop_front();
				nv = 1'b1;
				if (!no_idle && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 13);
				end
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tdata  <= nd;
	end

	// Grant side back-pressure: ready drops in bursts counted down by sink_gap, except with no_idle set.
	always @(negedge clk) begin
		logic r;
		if (sink_gap > 0 && !no_idle) begin
			sink_gap--;
			r = 1'b0;
		end else begin
			r = 1'b1;
			if (!no_idle && $urandom_range(0, 11) == 0) begin
				sink_gap = $urandom_range(1, 13);
			end
		end
		m_axis_tready <= r;
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge checks an accepted grant word against the
	// oldest prediction, then predicts the grant for an accepted request word.
	// The result check comes first so a grant can never meet its own request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		grant_t got;
		grant_t want;
		req_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[4:0];
			if (expected_grants.size() == 0) begin
				report_mismatch($sformatf("grant word 0x%02h with no request outstanding",
					m_axis_tdata));
			end else begin
				want = expected_grants.pop_front();
				if (got.granted !== want.granted) begin
					report_mismatch($sformatf("granted: expected %0d, got %0d",
						want.granted, got.granted));
				end
				if (got.chosen_slot !== want.chosen_slot) begin
					report_mismatch($sformatf("chosen_slot: expected %0d, got %0d",
						want.chosen_slot, got.chosen_slot));
				end
				if (got.from_high !== want.from_high) begin
					report_mismatch($sformatf("from_high: expected %0d, got %0d",
						want.from_high, got.from_high));
				end
			end
		end
		if (req_taken) begin
			expected_grants.push_back(predict_grant(s_axis_tdata));
		end
	end

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Waits until every queued word has gone in and every grant has come out,
	// then lets the request and grant registers settle before anything is reconfigured.
	task automatic drain();
		while (pending_masks.size() != 0 || s_axis_tvalid || expected_grants.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// A register write is a one-cycle strobe on cfg_we; the predictor follows once it has landed.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PART_WEIGHTS) begin
			mdl_parts = val;
		end else begin
			mdl_high = val[7:0];
		end
		regroup();
	endtask

	// Queues request words in runs of one shape, so that held masks let a slot
	// use up its part and the pointer has to move on.
	task automatic queue_requests(input int count);
		req_kind_t  kind;
		logic [7:0] hold;
		int         run;
		while (count > 0) begin
			run  = $urandom_range(1, 16);
			kind = req_kind_t'($urandom_range(0, 4));
			hold = 8'($urandom);
			while (run > 0 && count > 0) begin
				case (kind)
					REQ_FRESH:   pending_masks.push_back(8'($urandom));
					REQ_HOLD:    pending_masks.push_back(hold);
					REQ_ONE_HOT: pending_masks.push_back(8'(1) << $urandom_range(0, 7));
					REQ_ALL:     pending_masks.push_back(8'hFF);
					default:     pending_masks.push_back(8'h00);
				endcase
				run--;
				count--;
			end
		end
	endtask

	// Random part settings: mostly small parts so pointers move often, with
	// zeros sprinkled in to leave slots unused.
	function automatic logic [63:0] random_parts();
		logic [63:0] w;
		logic [7:0]  part;
		int          style;
		int          i;
		w = '0;
		style = $urandom_range(0, 2);
		for (i = 0; i < 8; i++) begin
			case (style)
				0:       part = 8'($urandom_range(0, 4));
				1:       part = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
				default: part = 8'($urandom_range(1, 2));
			endcase
			w[8*i +: 8] = part;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int ph;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Straight out of reset every slot is unused, so nothing can be granted.
		pending_masks.push_back(8'h00);
		pending_masks.push_back(8'hFF);
		pending_masks.push_back(8'h01);
		pending_masks.push_back(8'h80);
		drain();

		// Parts 1,2,1,255,2,0,1,3 from slot 0 up. Slots 1, 2 and 7 are high;
		// slot 5 has its high bit set but a zero part, so it is unused.
		write_reg(REG_PART_WEIGHTS, 64'h03_01_00_02_FF_01_02_01);
		write_reg(REG_HIGH_MASK, 64'b1010_0110);
		// All queues full: the high group cycles through its parts.
		repeat (5) pending_masks.push_back(8'hFF);
		// Nothing available at all.
		pending_masks.push_back(8'h00);
		// Only the unused slot asks: still nothing.
		pending_masks.push_back(8'h20);
		// Low group only, with the high count cleared while it grants nothing.
		pending_masks.push_back(8'h01);
		pending_masks.push_back(8'h08);
		pending_masks.push_back(8'h08);
		pending_masks.push_back(8'h10);
		pending_masks.push_back(8'h40);
		pending_masks.push_back(8'h59);
		// High group single requests and mixes of both groups.
		pending_masks.push_back(8'h80);
		pending_masks.push_back(8'h86);
		pending_masks.push_back(8'h79);
		pending_masks.push_back(8'hFF);
		drain();

		// Largest parts everywhere, all in the high group: the low group is empty.
		write_reg(REG_PART_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_HIGH_MASK, 64'hFF);
		queue_requests(100);
		drain();

		// Smallest parts everywhere, all in the low group: the high group is empty.
		write_reg(REG_PART_WEIGHTS, 64'h0101_0101_0101_0101);
		write_reg(REG_HIGH_MASK, 64'h00);
		queue_requests(100);
		drain();

		// One slot with the largest part kept busy long enough to spend it all,
		// so the count runs to its ceiling and the pointer laps back.
		write_reg(REG_PART_WEIGHTS, 64'h0101_0101_FF01_0101);
		repeat (270) pending_masks.push_back(8'h08);
		drain();

		// Random settings; sometimes only one register is rewritten. The last
		// phase runs with no idling on either side.
		for (ph = 0; ph < 8; ph++) begin
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_PART_WEIGHTS, random_parts());
			end
			write_reg(REG_HIGH_MASK, 64'(8'($urandom)));
			if (ph == 7) begin
				no_idle = 1'b1;
			end
			queue_requests(100);
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("two_level_weighted_round_robin: match");
		end else begin
			$display("two_level_weighted_round_robin: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of about 1300 words.
	initial begin
		#5_000_000;
		$display("two_level_weighted_round_robin: mismatch");
		$finish;
	end

endmodule

// ----- two_level_weighted_round_robin.f -----
rtl/core/twrr_pkg.sv
rtl/core/two_level_weighted_round_robin.sv
dv/two_level_weighted_round_robin_tb.sv
